// ===== sv/banker_safety_check_defines.svh =====
// Assertion macros used by the checker file.
`ifndef BANKER_SAFETY_CHECK_DEFINES_SVH
`define BANKER_SAFETY_CHECK_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define BSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define BSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/bsc_pkg.sv =====
package bsc_pkg;

  localparam logic [1:0] OP_WRITE_ENTRY = 2'd0;
  localparam logic [1:0] OP_WRITE_TOTAL = 2'd1;
  localparam logic [1:0] OP_CHECK       = 2'd2;
  localparam logic [1:0] OP_TRIAL       = 2'd3;

  localparam logic [1:0] ST_SEQ    = 2'd0;
  localparam logic [1:0] ST_UNSAFE = 2'd1;
  localparam logic [1:0] ST_ACCEPT = 2'd2;
  localparam logic [1:0] ST_REJECT = 2'd3;

  typedef struct packed {
    logic clr_step;
    logic wr_entry;
    logic wr_total;
    logic load;
    logic addr_trial;
    logic save_old;
    logic wr_trial;
    logic wr_back;
    logic p_clr;
    logic p_inc;
    logic r_clr;
    logic r_inc;
    logic fin_clr;
    logic work_init;
    logic work_sub;
    logic work_add;
    logic grant;
    logic emit_seq;
    logic emit_unsafe;
    logic emit_accept;
    logic emit_reject;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic p_last;
    logic r_last;
    logic done_last;
    logic fin_p;
    logic fits;
    logic in_ok;
  } stat_t;

endpackage

// ===== sv/bsc_ctrl.sv =====
module bsc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [1:0]     opcode,
  input  bsc_pkg::stat_t stat,
  output bsc_pkg::cmd_t  cmd,
  output logic           busy
);
  import bsc_pkg::*;

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_TR_READ  = 4'd2;
  localparam logic [3:0] S_TR_SAVE  = 4'd3;
  localparam logic [3:0] S_AV_START = 4'd4;
  localparam logic [3:0] S_AV_INIT  = 4'd5;
  localparam logic [3:0] S_AV_ADDR  = 4'd6;
  localparam logic [3:0] S_AV_SUB   = 4'd7;
  localparam logic [3:0] S_GR_SKIP  = 4'd8;
  localparam logic [3:0] S_FIT_ADDR = 4'd9;
  localparam logic [3:0] S_FIT_CMP  = 4'd10;
  localparam logic [3:0] S_ADD_ADDR = 4'd11;
  localparam logic [3:0] S_ADD_DO   = 4'd12;
  localparam logic [3:0] S_SAFE_END = 4'd13;
  localparam logic [3:0] S_EMIT     = 4'd14;
  localparam logic [3:0] S_UNSAFE   = 4'd15;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       is_trial;
  logic       is_trial_next;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      is_trial <= 1'b0;
    end else begin
      state    <= state_next;
      is_trial <= is_trial_next;
    end
  end

  always_comb begin
    cmd           = '0;
    state_next    = state;
    is_trial_next = is_trial;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          case (opcode)
            OP_WRITE_ENTRY: cmd.wr_entry = 1'b1;
            OP_WRITE_TOTAL: cmd.wr_total = 1'b1;
            OP_CHECK: begin
              cmd.load      = 1'b1;
              is_trial_next = 1'b0;
              state_next    = S_AV_START;
            end
            OP_TRIAL: begin
              // An update that addresses no table entry is refused on the spot.
              if (stat.in_ok) begin
                cmd.load      = 1'b1;
                is_trial_next = 1'b1;
                state_next    = S_TR_READ;
              end else begin
                cmd.emit_reject = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_TR_READ: begin
        cmd.addr_trial = 1'b1;
        state_next     = S_TR_SAVE;
      end
      S_TR_SAVE: begin
        cmd.save_old = 1'b1;
        cmd.wr_trial = 1'b1;
        state_next   = S_AV_START;
      end
      S_AV_START: begin
        cmd.p_clr   = 1'b1;
        cmd.r_clr   = 1'b1;
        cmd.fin_clr = 1'b1;
        state_next  = S_AV_INIT;
      end
      S_AV_INIT: begin
        cmd.work_init = 1'b1;
        state_next    = S_AV_SUB;
      end
      S_AV_ADDR: begin
        state_next = S_AV_SUB;
      end
      S_AV_SUB: begin
        cmd.work_sub = 1'b1;
        if (stat.p_last) begin
          cmd.p_clr = 1'b1;
          if (stat.r_last) begin
            cmd.r_clr  = 1'b1;
            state_next = S_GR_SKIP;
          end else begin
            cmd.r_inc  = 1'b1;
            state_next = S_AV_INIT;
          end
        end else begin
          cmd.p_inc  = 1'b1;
          state_next = S_AV_ADDR;
        end
      end
      S_GR_SKIP: begin
        if (!stat.fin_p) begin
          cmd.r_clr  = 1'b1;
          state_next = S_FIT_ADDR;
        end else if (stat.p_last) begin
          state_next = S_UNSAFE;
        end else begin
          cmd.p_inc = 1'b1;
        end
      end
      S_FIT_ADDR: begin
        state_next = S_FIT_CMP;
      end
      S_FIT_CMP: begin
        if (!stat.fits) begin
          if (stat.p_last) begin
            state_next = S_UNSAFE;
          end else begin
            cmd.p_inc  = 1'b1;
            state_next = S_GR_SKIP;
          end
        end else if (stat.r_last) begin
          cmd.r_clr  = 1'b1;
          state_next = S_ADD_ADDR;
        end else begin
          cmd.r_inc  = 1'b1;
          state_next = S_FIT_ADDR;
        end
      end
      S_ADD_ADDR: begin
        state_next = S_ADD_DO;
      end
      S_ADD_DO: begin
        cmd.work_add = 1'b1;
        if (stat.r_last) begin
          cmd.grant = 1'b1;
          cmd.p_clr = 1'b1;
          if (stat.done_last) begin
            state_next = S_SAFE_END;
          end else begin
            state_next = S_GR_SKIP;
          end
        end else begin
          cmd.r_inc  = 1'b1;
          state_next = S_ADD_ADDR;
        end
      end
      S_SAFE_END: begin
        if (is_trial) begin
          cmd.emit_accept = 1'b1;
          state_next      = S_IDLE;
        end else begin
          cmd.p_clr  = 1'b1;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit_seq = 1'b1;
        if (stat.p_last) begin
          state_next = S_IDLE;
        end else begin
          cmd.p_inc = 1'b1;
        end
      end
      S_UNSAFE: begin
        if (is_trial) begin
          cmd.wr_back     = 1'b1;
          cmd.emit_reject = 1'b1;
        end else begin
          cmd.emit_unsafe = 1'b1;
        end
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== sv/bsc_datapath.sv =====
module bsc_datapath #(
  parameter int MAX_PROCS  = 16,
  parameter int MAX_RES    = 8,
  parameter int COUNT_BITS = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  bsc_pkg::cmd_t  cmd,
  output bsc_pkg::stat_t stat,
  input  logic [4:0]     proc_count,
  input  logic [3:0]     res_count,
  input  logic [3:0]     process_index,
  input  logic [2:0]     resource_index,
  input  logic [7:0]     max_value,
  input  logic [7:0]     alloc_value,
  input  logic [7:0]     total_value,
  output logic           result_valid,
  output logic [1:0]     status,
  output logic [3:0]     seq_process,
  output logic           last
);
  import bsc_pkg::*;

  localparam int CB    = COUNT_BITS;
  localparam int EW    = 2 * CB;
  localparam int WW    = CB + 5;
  localparam int DEPTH = MAX_PROCS * MAX_RES;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(MAX_PROCS);
  localparam int RW    = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
  localparam int SL    = (MAX_PROCS < 16) ? MAX_PROCS : 16;
  localparam int SLW   = $clog2(SL);

  logic [EW-1:0]        mem [DEPTH];
  logic [EW-1:0]        rdata;
  logic [AW-1:0]        raddr;
  logic [AW-1:0]        waddr;
  logic [EW-1:0]        wdata;
  logic                 we;

  logic [AW-1:0]        clr_cnt;
  logic [PW-1:0]        p_cnt;
  logic [RW-1:0]        r_cnt;
  logic [SLW-1:0]       done_cnt;
  logic                 finished [MAX_PROCS];
  logic signed [WW-1:0] work [MAX_RES];
  logic [CB-1:0]        totals [MAX_RES];
  logic [3:0]           order [SL];
  logic [EW-1:0]        saved;
  logic [AW-1:0]        t_addr;
  logic [CB-1:0]        t_mv;
  logic [CB-1:0]        t_av;

  logic [AW-1:0]        cnt_addr;
  logic [AW-1:0]        in_addr;
  logic                 p_in_ok;
  logic                 r_in_ok;
  logic [6:0]           np_m1;
  logic [4:0]           nr_m1;
  logic signed [WW-1:0] alloc_w;
  logic signed [WW-1:0] need_w;

  assign cnt_addr = AW'(int'(p_cnt) * MAX_RES + int'(r_cnt));
  assign in_addr  = AW'(int'(process_index) * MAX_RES + int'(resource_index));
  assign p_in_ok  = (int'(process_index) < MAX_PROCS);
  assign r_in_ok  = (int'(resource_index) < MAX_RES);

  // Counts out of range saturate to the supported span.
  always_comb begin
    if (proc_count == 5'd0) begin
      np_m1 = 7'd0;
    end else if (7'(proc_count) > 7'(SL)) begin
      np_m1 = 7'(SL - 1);
    end else begin
      np_m1 = 7'(proc_count) - 7'd1;
    end
    if (res_count == 4'd0) begin
      nr_m1 = 5'd0;
    end else if (5'(res_count) > 5'(MAX_RES)) begin
      nr_m1 = 5'(MAX_RES - 1);
    end else begin
      nr_m1 = 5'(res_count) - 5'd1;
    end
  end

  assign alloc_w = $signed(WW'(rdata[CB-1:0]));
  assign need_w  = $signed(WW'(rdata[EW-1:CB])) - alloc_w;

  assign stat.clr_last  = (clr_cnt == AW'(DEPTH - 1));
  assign stat.p_last    = (7'(p_cnt) == np_m1);
  assign stat.r_last    = (5'(r_cnt) == nr_m1);
  assign stat.done_last = (7'(done_cnt) == np_m1);
  assign stat.fin_p     = finished[p_cnt];
  assign stat.fits      = !(need_w > work[r_cnt]);
  assign stat.in_ok     = p_in_ok && r_in_ok;

  // Table memory: one write port, one registered read port.
  assign raddr = cmd.addr_trial ? t_addr : cnt_addr;

  always_comb begin
    we    = 1'b0;
    waddr = t_addr;
    wdata = saved;
    if (cmd.clr_step) begin
      we    = 1'b1;
      waddr = clr_cnt;
      wdata = '0;
    end else if (cmd.wr_entry && p_in_ok && r_in_ok) begin
      we    = 1'b1;
      waddr = in_addr;
      wdata = {CB'(max_value), CB'(alloc_value)};
    end else if (cmd.wr_trial) begin
      we    = 1'b1;
      wdata = {t_mv, t_av};
    end else if (cmd.wr_back) begin
      we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt  <= '0;
      p_cnt    <= '0;
      r_cnt    <= '0;
      done_cnt <= '0;
      for (int i = 0; i < MAX_PROCS; i++) begin
        finished[i] <= 1'b0;
      end
      for (int i = 0; i < MAX_RES; i++) begin
        totals[i] <= '0;
      end
    end else begin
      if (cmd.clr_step) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (cmd.p_clr) begin
        p_cnt <= '0;
      end else if (cmd.p_inc) begin
        p_cnt <= p_cnt + PW'(1);
      end
      if (cmd.r_clr) begin
        r_cnt <= '0;
      end else if (cmd.r_inc) begin
        r_cnt <= r_cnt + RW'(1);
      end
      if (cmd.fin_clr) begin
        done_cnt <= '0;
        for (int i = 0; i < MAX_PROCS; i++) begin
          finished[i] <= 1'b0;
        end
      end else if (cmd.grant) begin
        done_cnt        <= done_cnt + SLW'(1);
        finished[p_cnt] <= 1'b1;
      end
      if (cmd.wr_total && r_in_ok) begin
        totals[RW'(resource_index)] <= CB'(total_value);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.work_init) begin
      work[r_cnt] <= $signed(WW'(totals[r_cnt]));
    end else if (cmd.work_sub) begin
      work[r_cnt] <= work[r_cnt] - alloc_w;
    end else if (cmd.work_add) begin
      work[r_cnt] <= work[r_cnt] + alloc_w;
    end
    if (cmd.grant) begin
      order[done_cnt] <= 4'(p_cnt);
    end
    if (cmd.save_old) begin
      saved <= rdata;
    end
    if (cmd.load) begin
      t_addr <= in_addr;
      t_mv   <= CB'(max_value);
      t_av   <= CB'(alloc_value);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit_seq || cmd.emit_unsafe || cmd.emit_accept || cmd.emit_reject;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_seq) begin
      status      <= ST_SEQ;
      seq_process <= order[p_cnt[SLW-1:0]];
      last        <= stat.p_last;
    end else if (cmd.emit_unsafe || cmd.emit_accept || cmd.emit_reject) begin
      seq_process <= 4'd0;
      last        <= 1'b1;
      if (cmd.emit_unsafe) begin
        status <= ST_UNSAFE;
      end else if (cmd.emit_accept) begin
        status <= ST_ACCEPT;
      end else begin
        status <= ST_REJECT;
      end
    end
  end

endmodule

// ===== sv/banker_safety_check.sv =====
// Channel   Handshake                   Payload
// input     start, busy                 opcode, process_index, resource_index,
//                                       max_value, alloc_value, total_value
// result    result_valid (one cycle)    status, seq_process, last
// config    psel, penable, pwrite,      paddr, pwdata, prdata
//           pready
//
// Table and total writes leave busy low and may follow back to back.
// A check walks the tables through the single read port of the table memory: it first
// works out what is available over all P*R entries, then runs at most P*(P+1)/2 fit
// tests, each over up to R resources, granting each process that fits, passing over each
// finished process, and sends the sequence if safe. A trial update first saves the old
// entry. P and R are the process and resource counts; busy stays high for the whole walk.
// After reset the table memory is cleared, one entry a cycle over all MAX_PROCS*MAX_RES
// entries, with busy high. Results cannot be held off; each shows for one cycle.
module banker_safety_check #(
  parameter int MAX_PROCS  = 16,
  parameter int MAX_RES    = 8,
  parameter int COUNT_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [3:0]  process_index,
  input  logic [2:0]  resource_index,
  input  logic [7:0]  max_value,
  input  logic [7:0]  alloc_value,
  input  logic [7:0]  total_value,
  output logic        result_valid,
  output logic [1:0]  status,
  output logic [3:0]  seq_process,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bsc_pkg::*;

  cmd_t       cmd;
  stat_t      stat;
  logic [4:0] proc_count;
  logic [3:0] res_count;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      proc_count <= 5'd1;
      res_count  <= 4'd1;
    end else if (cfg_write) begin
      if (paddr[2]) begin
        res_count <= pwdata[3:0];
      end else begin
        proc_count <= pwdata[4:0];
      end
    end
  end

  assign prdata = paddr[2] ? {28'd0, res_count} : {27'd0, proc_count};

  bsc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  bsc_datapath #(
    .MAX_PROCS  (MAX_PROCS),
    .MAX_RES    (MAX_RES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .proc_count     (proc_count),
    .res_count      (res_count),
    .process_index  (process_index),
    .resource_index (resource_index),
    .max_value      (max_value),
    .alloc_value    (alloc_value),
    .total_value    (total_value),
    .result_valid   (result_valid),
    .status         (status),
    .seq_process    (seq_process),
    .last           (last)
  );

endmodule

// ===== sv/bsc_checker.sv =====
`include "banker_safety_check_defines.svh"

module bsc_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] opcode,
  input logic       result_valid,
  input logic [1:0] status,
  input logic [3:0] seq_process,
  input logic       last,
  input logic       pready
);
  import bsc_pkg::*;

  `BSC_ASSERT_NOW(a_pready_high, 1'b1, pready, "pready dropped")

  // Table and total writes complete in the cycle they are taken.
  `BSC_ASSERT_NEXT(a_write_no_busy, start && !busy && (opcode == OP_WRITE_ENTRY || opcode == OP_WRITE_TOTAL), !busy, "write item left the block busy")

  `BSC_ASSERT_NEXT(a_check_busy, start && !busy && opcode == OP_CHECK, busy, "check item did not start a walk")

  // Only sequence entries carry a process number; every other result ends its item.
  `BSC_ASSERT_NOW(a_single_result, result_valid && status != ST_SEQ, last && seq_process == 4'd0, "non-sequence result malformed")

  `BSC_ASSERT_NOW(a_result_cause, result_valid, $past(busy) || $past(start && opcode == OP_TRIAL), "result with no item in work")

endmodule

bind banker_safety_check bsc_checker u_bsc_checker (.*);

// ===== test/banker_safety_check_checker.sv =====
module banker_safety_check_checker #(
  parameter logic [2:0] PROC_COUNT_ADDR = 3'd0,
  parameter logic [2:0] RES_COUNT_ADDR  = 3'd4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  opcode,
  input  logic [3:0]  process_index,
  input  logic [2:0]  resource_index,
  input  logic [7:0]  max_value,
  input  logic [7:0]  alloc_value,
  input  logic [7:0]  total_value,
  input  logic        result_valid,
  input  logic [1:0]  status,
  input  logic [3:0]  seq_process,
  input  logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          pending
);
  import bsc_pkg::*;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] proc;
    logic       last;
  } outcome_t;

  logic [7:0] claim_tab [16][8];
  logic [7:0] held_tab [16][8];
  logic [7:0] unit_total [8];
  logic [4:0] proc_reg;
  logic [3:0] res_reg;
  outcome_t   outcome_q [$];
  outcome_t   want;

  function automatic int procs_in_use();
    if (proc_reg == 5'd0) return 1;
    if (proc_reg > 5'd16) return 16;
    return int'(proc_reg);
  endfunction

  function automatic int res_in_use();
    if (res_reg == 4'd0) return 1;
    if (res_reg > 4'd8) return 8;
    return int'(res_reg);
  endfunction

  task automatic queue_outcome(input logic [1:0] st, input logic [3:0] pr, input logic lst);
    outcome_q.insert(outcome_q.size(), outcome_t'{st, pr, lst});
  endtask

  // Need and available are signed: an allocation above the claim gives a negative need,
  // and an overcommitted resource only admits processes with negative need.
  function automatic bit walk_is_safe(output logic [3:0] order [16]);
    int np, nr, done, need, p, r;
    int work [8];
    bit finished [16];
    bit granted, fits;
    np = procs_in_use();
    nr = res_in_use();
    for (r = 0; r < 8; r++) begin
      work[r] = int'(unit_total[r]);
      for (p = 0; p < np; p++) work[r] -= int'(held_tab[p][r]);
    end
    for (p = 0; p < 16; p++) begin
      finished[p] = 1'b0;
      order[p] = 4'd0;
    end
    done = 0;
    while (done < np) begin
      granted = 1'b0;
      for (p = 0; p < np && !granted; p++) begin
        if (!finished[p]) begin
          fits = 1'b1;
          for (r = 0; r < nr; r++) begin
            need = int'(claim_tab[p][r]) - int'(held_tab[p][r]);
            if (need > work[r]) fits = 1'b0;
          end
          if (fits) begin
            for (r = 0; r < nr; r++) work[r] += int'(held_tab[p][r]);
            finished[p] = 1'b1;
            order[done] = p[3:0];
            done++;
            granted = 1'b1;
          end
        end
      end
      if (!granted) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic predict_item(input logic [1:0] op, input logic [3:0] p, input logic [2:0] r,
                              input logic [7:0] mv, input logic [7:0] av,
                              input logic [7:0] tv);
    logic [3:0] order [16];
    logic [7:0] old_claim, old_held;
    int np, i;
    np = procs_in_use();
    case (op)
      OP_WRITE_ENTRY: begin
        claim_tab[p][r] = mv;
        held_tab[p][r] = av;
      end
      OP_WRITE_TOTAL: begin
        unit_total[r] = tv;
      end
      OP_CHECK: begin
        if (walk_is_safe(order)) begin
          for (i = 0; i < np; i++)
            queue_outcome(ST_SEQ, order[i], i == np - 1);
        end else begin
          queue_outcome(ST_UNSAFE, 4'd0, 1'b1);
        end
      end
      default: begin
        old_claim = claim_tab[p][r];
        old_held = held_tab[p][r];
        claim_tab[p][r] = mv;
        held_tab[p][r] = av;
        if (walk_is_safe(order)) begin
          queue_outcome(ST_ACCEPT, 4'd0, 1'b1);
        end else begin
          claim_tab[p][r] = old_claim;
          held_tab[p][r] = old_held;
          queue_outcome(ST_REJECT, 4'd0, 1'b1);
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < 16; p++) begin
        for (int r = 0; r < 8; r++) begin
          claim_tab[p][r] = 8'd0;
          held_tab[p][r] = 8'd0;
        end
      end
      for (int r = 0; r < 8; r++) unit_total[r] = 8'd0;
      proc_reg = 5'd1;
      res_reg = 4'd1;
      outcome_q.delete();
      mismatches = 0;
    end else begin
      if (result_valid) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, got status %0d process %0d last %0d",
                   $time, status, seq_process, last);
          mismatches++;
        end else begin
          want = outcome_q.pop_front();
          if (status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, got %0d", $time, want.status, status);
            mismatches++;
          end
          if (seq_process !== want.proc) begin
            $display("%0t: seq_process mismatch: expected %0d, got %0d",
                     $time, want.proc, seq_process);
            mismatches++;
          end
          if (last !== want.last) begin
            $display("%0t: last mismatch: expected %0d, got %0d", $time, want.last, last);
            mismatches++;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr == PROC_COUNT_ADDR) proc_reg = pwdata[4:0];
        else if (paddr == RES_COUNT_ADDR) res_reg = pwdata[3:0];
      end
      if (start && !busy)
        predict_item(opcode, process_index, resource_index, max_value, alloc_value,
                     total_value);
    end
    pending = outcome_q.size();
  end

endmodule

// ===== test/testbench.sv =====
module testbench;
  import bsc_pkg::*;

  localparam logic [2:0] PROC_COUNT_ADDR = 3'd0;
  localparam logic [2:0] RES_COUNT_ADDR  = 3'd4;
  localparam int ITEM_TARGET  = 480;
  localparam int QUIET_FROM   = 430;
  localparam int TAIL_CYCLES  = 40;
  localparam int CYCLE_LIMIT  = 12_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  opcode = 2'd0;
  logic [3:0]  process_index = 4'd0;
  logic [2:0]  resource_index = 3'd0;
  logic [7:0]  max_value = 8'd0;
  logic [7:0]  alloc_value = 8'd0;
  logic [7:0]  total_value = 8'd0;
  logic        result_valid;
  logic [1:0]  status;
  logic [3:0]  seq_process;
  logic        last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;
  int          mismatches;
  int          pending;
  int          items_sent = 0;
  int          act_procs = 1;
  int          act_res = 1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  banker_safety_check dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(opcode), .process_index(process_index), .resource_index(resource_index),
    .max_value(max_value), .alloc_value(alloc_value), .total_value(total_value),
    .result_valid(result_valid), .status(status), .seq_process(seq_process), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  banker_safety_check_checker #(
    .PROC_COUNT_ADDR(PROC_COUNT_ADDR),
    .RES_COUNT_ADDR(RES_COUNT_ADDR)
  ) chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(opcode), .process_index(process_index), .resource_index(resource_index),
    .max_value(max_value), .alloc_value(alloc_value), .total_value(total_value),
    .result_valid(result_valid), .status(status), .seq_process(seq_process), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready), .mismatches(mismatches), .pending(pending)
  );

  function automatic int any8();
    return $urandom_range(0, 255);
  endfunction

  // All driver tasks start and end just after a falling edge.
  task automatic send_item(input logic [1:0] op, input int p, input int r, input int mv,
                           input int av, input int tv);
    opcode = op;
    process_index = p[3:0];
    resource_index = r[2:0];
    max_value = mv[7:0];
    alloc_value = av[7:0];
    total_value = tv[7:0];
    start = 1'b1;
    do @(posedge clk); while (busy);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic put_entry(input int p, input int r, input int mv, input int av);
    send_item(OP_WRITE_ENTRY, p, r, mv, av, any8());
  endtask

  task automatic put_total(input int r, input int tv);
    send_item(OP_WRITE_TOTAL, $urandom_range(0, 15), r, any8(), any8(), tv);
  endtask

  task automatic run_check();
    send_item(OP_CHECK, $urandom_range(0, 15), $urandom_range(0, 7), any8(), any8(), any8());
  endtask

  task automatic try_update(input int p, input int r, input int mv, input int av);
    send_item(OP_TRIAL, p, r, mv, av, any8());
  endtask

  task automatic rest(input int n);
    start = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Holds off until every expected result is in and the block has gone idle.
  task automatic drain();
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input int data);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic configure(input int pc, input int rc);
    drain();
    apb_write(PROC_COUNT_ADDR, pc);
    apb_write(RES_COUNT_ADDR, rc);
    act_procs = (pc < 1) ? 1 : (pc > 16) ? 16 : pc;
    act_res = (rc < 1) ? 1 : (rc > 8) ? 8 : rc;
  endtask

  task automatic gap();
    if (items_sent < QUIET_FROM) begin
      if ($urandom_range(0, 3) == 0) rest($urandom_range(1, 8));
      else if ($urandom_range(0, 39) == 0) drain();
    end
  endtask

  // Mostly consistent tables: small holdings, modest remaining claims, and totals
  // that are sometimes short, so that both safe and unsafe outcomes come up.
  task automatic load_tables();
    int p, r, av, mv;
    for (r = 0; r < act_res; r++) begin
      if (items_sent < ITEM_TARGET) begin
        gap();
        put_total(r, (6 * act_procs + 4 > 255) ? any8()
                                               : $urandom_range(act_procs, 6 * act_procs + 4));
      end
    end
    for (p = 0; p < act_procs; p++) begin
      for (r = 0; r < act_res; r++) begin
        if (items_sent < ITEM_TARGET) begin
          gap();
          av = $urandom_range(0, 4);
          mv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, av) : av + $urandom_range(0, 8);
          put_entry(p, r, mv, av);
        end
      end
    end
  endtask

  task automatic random_op();
    int k, p, r, av;
    k = $urandom_range(0, 99);
    p = $urandom_range(0, act_procs - 1);
    r = $urandom_range(0, act_res - 1);
    av = $urandom_range(0, 6);
    if (k < 30) run_check();
    else if (k < 47) try_update(p, r, av + $urandom_range(0, 10), av);
    else if (k < 55) try_update($urandom_range(0, 15), $urandom_range(0, 7), any8(), any8());
    else if (k < 75) put_entry(p, r, av + $urandom_range(0, 10), av);
    else if (k < 82) put_total(r, $urandom_range(0, 8 * act_procs));
    else if (k < 92) put_entry($urandom_range(0, 15), $urandom_range(0, 7), any8(), any8());
    else put_total($urandom_range(0, 7), any8());
  endtask

  task automatic run_phase();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind == 0) configure(16, 8);
    else if (kind == 1)
      configure($urandom_range(0, 1) ? 0 : $urandom_range(17, 31),
                $urandom_range(0, 1) ? 0 : $urandom_range(9, 15));
    else configure($urandom_range(1, 6), $urandom_range(1, 3));
    load_tables();
    repeat ($urandom_range(15, 35)) begin
      if (items_sent < ITEM_TARGET) begin
        gap();
        random_op();
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    drain();

    // Registers still at their reset values: one process, one resource.
    run_check();
    configure(4, 2);
    put_total(0, 10);
    put_total(1, 5);
    put_entry(0, 0, 8, 2);
    put_entry(1, 0, 3, 1);
    put_entry(2, 0, 0, 0);
    put_entry(3, 0, 255, 0);
    run_check();
    try_update(3, 0, 5, 0);
    try_update(3, 0, 255, 0);
    run_check();
    // Allocation above both the claim and the total of resource 1.
    put_entry(1, 1, 0, 200);
    run_check();
    // Entries outside the counts are kept but take no part.
    put_entry(15, 7, 255, 255);
    put_total(7, 255);
    run_check();
    configure(16, 8);
    run_check();
    try_update(0, 7, 0, 255);
    configure(0, 0);
    run_check();
    configure(31, 15);
    run_check();
    try_update(8, 3, 255, 0);

    while (items_sent < ITEM_TARGET) run_phase();

    drain();
    if (mismatches == 0 && pending == 0) begin
      $display("** banker_safety_check: PASSED **");
    end else begin
      $display("** banker_safety_check: FAILED **");
    end
    $finish;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("** banker_safety_check: FAILED **");
    $finish;
  end

endmodule
